### design/thhs_pkg.sv
`timescale 1ns / 1ps

package thhs_pkg;

	// Header bytes held before a buffer is classified
	localparam int HEADER_BYTES = 11;
	// Wide enough for 0..HEADER_BYTES+1 (header index, flush length, flush step)
	localparam int HDR_IDX_W = $clog2(HEADER_BYTES + 2);
	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// Result byte for the newline segment sent ahead of an HTTP request
	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_TLS   = 2'd1,
		CLS_HTTP  = 2'd2
	} cls_t;

	typedef enum logic {
		CMD_BYTE  = 1'b0,
		CMD_FLUSH = 1'b1
	} cmd_t;

	// One queued command: a single result, or a flush of the held header
	typedef struct packed {
		cmd_t                              kind;
		cls_t                              cls;
		logic [7:0]                        data;
		logic                              has;
		logic                              seg;
		logic                              done;
		logic [15:0]                       count;
		logic [HDR_IDX_W-1:0]              nbytes;
		logic                              newline;
		logic                              seg_each;
		logic [HEADER_BYTES-1:0][7:0]      hdr;
	} entry_t;

endpackage

### design/thhs_front.sv
`timescale 1ns / 1ps

module thhs_front
	import thhs_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  logic [7:0]   in_byte,
	input  logic         last_byte,
	input  logic [7:0]   fragment_limit,
	output logic         push,
	output entry_t       push_entry
);

	localparam int METHOD_COUNT = 7;
	localparam int METHOD_MAX   = 8;
	localparam int METHOD_LEN [METHOD_COUNT] = '{4, 5, 5, 4, 7, 8, 8};
	localparam logic [7:0] METHOD_TEXT [METHOD_COUNT][METHOD_MAX] = '{
		'{"G", "E", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"H", "E", "A", "D", " ", 8'h00, 8'h00, 8'h00},
		'{"P", "O", "S", "T", " ", 8'h00, 8'h00, 8'h00},
		'{"P", "U", "T", " ", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"D", "E", "L", "E", "T", "E", " ", 8'h00},
		'{"C", "O", "N", "N", "E", "C", "T", " "},
		'{"O", "P", "T", "I", "O", "N", "S", " "}
	};

	localparam logic [7:0] TLS_HANDSHAKE    = 8'd22;
	localparam logic [7:0] TLS_CLIENT_HELLO = 8'd1;
	localparam logic [7:0] TLS_MAJOR        = 8'h03;
	localparam logic [7:0] TLS_MINOR_MAX    = 8'h03;

	logic [COUNT_BITS-1:0]         cnt_q;
	logic                          classified_q;
	cls_t                          cls_q;
	logic [7:0]                    held_q;
	logic [HEADER_BYTES-1:0][7:0]  hdr_q;

	logic [COUNT_BITS-1:0]         cnt_next;
	logic [HEADER_BYTES-1:0][7:0]  hdr_next;
	logic                          do_classify;
	logic [HDR_IDX_W-1:0]          len;
	cls_t                          new_cls;
	logic [7:0]                    tls_k;
	logic [15:0]                   count_sat;
	logic [15:0]                   count_tls;
	logic                          in_window;

	// Buffer class from the held header and its length
	function automatic cls_t classify(input logic [HEADER_BYTES-1:0][7:0] h,
			input logic [HDR_IDX_W-1:0] n);
		logic tls;
		logic http;
		logic match;
		tls = (n == HDR_IDX_W'(HEADER_BYTES)) && (h[0] == TLS_HANDSHAKE) &&
			(h[5] == TLS_CLIENT_HELLO) &&
			(h[1] == TLS_MAJOR) && (h[2] <= TLS_MINOR_MAX) &&
			(h[9] == TLS_MAJOR) && (h[10] <= TLS_MINOR_MAX);
		http = 1'b0;
		for (int m = 0; m < METHOD_COUNT; m++) begin
			match = (32'(n) >= METHOD_LEN[m]);
			for (int i = 0; i < METHOD_MAX; i++) begin
				if ((i < METHOD_LEN[m]) && (h[i] != METHOD_TEXT[m][i])) begin
					match = 1'b0;
				end
			end
			http = http | match;
		end
		if (tls) begin
			return CLS_TLS;
		end else if (http) begin
			return CLS_HTTP;
		end else begin
			return CLS_OTHER;
		end
	endfunction

	// Next count, header capture and classification
	always_comb begin
		cnt_next = (cnt_q == {COUNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
		hdr_next = hdr_q;
		if (32'(cnt_q) < HEADER_BYTES) begin
			hdr_next[cnt_q[HDR_IDX_W-1:0]] = in_byte;
		end
		do_classify = !classified_q &&
			(last_byte || (32'(cnt_next) >= HEADER_BYTES));
		len = cnt_next[HDR_IDX_W-1:0];
		new_cls = classify(hdr_next, len);
		tls_k = (32'(len) < 32'(fragment_limit)) ? 8'(len) : fragment_limit;
		count_sat = (32'(cnt_next) > 32'hFFFF) ? 16'hFFFF : 16'(32'(cnt_next));
		count_tls = (32'(cnt_next) < 32'(held_q)) ? 16'(32'(cnt_next)) : 16'(held_q);
		in_window = (32'(cnt_q) < 32'(held_q));
	end

	// Command for the accepted byte
	always_comb begin
		push = 1'b0;
		push_entry = '0;
		push_entry.done = last_byte;
		push_entry.hdr = hdr_next;
		if (!classified_q) begin
			push_entry.kind = CMD_FLUSH;
			push_entry.cls = new_cls;
			if (new_cls == CLS_TLS) begin
				push = accept && do_classify && (last_byte || (tls_k != 8'd0));
				push_entry.nbytes = HDR_IDX_W'(tls_k);
				push_entry.seg_each = 1'b1;
				push_entry.count = 16'(tls_k);
			end else begin
				push = accept && do_classify;
				push_entry.nbytes = len;
				push_entry.newline = (new_cls == CLS_HTTP);
				push_entry.count = count_sat;
			end
		end else if (cls_q == CLS_TLS) begin
			push = accept && (in_window || last_byte);
			push_entry.kind = CMD_BYTE;
			push_entry.cls = cls_q;
			push_entry.data = in_window ? in_byte : 8'd0;
			push_entry.has = in_window;
			push_entry.seg = in_window;
			push_entry.count = count_tls;
		end else begin
			push = accept;
			push_entry.kind = CMD_BYTE;
			push_entry.cls = cls_q;
			push_entry.data = in_byte;
			push_entry.has = 1'b1;
			push_entry.seg = last_byte;
			push_entry.count = count_sat;
		end
	end

	// Per-buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			classified_q <= 1'b0;
			cls_q <= CLS_OTHER;
			held_q <= 8'd0;
		end else if (accept) begin
			if (last_byte) begin
				cnt_q <= '0;
				classified_q <= 1'b0;
				cls_q <= CLS_OTHER;
			end else begin
				cnt_q <= cnt_next;
				if (do_classify) begin
					classified_q <= 1'b1;
					cls_q <= new_cls;
				end
			end
			if (do_classify) begin
				held_q <= fragment_limit;
			end
		end
	end

	// Header bytes, payload only
	always_ff @(posedge clk) begin
		if (accept && !classified_q) begin
			hdr_q <= hdr_next;
		end
	end

endmodule

### design/thhs_queue.sv
`timescale 1ns / 1ps

module thhs_queue
	import thhs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_entry,
	input  logic    pop,
	output logic    full,
	output logic    empty,
	output entry_t  head
);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     fill_q;

	assign full  = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

### design/thhs_back.sv
`timescale 1ns / 1ps

module thhs_back
	import thhs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         empty,
	input  entry_t       head,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [7:0]   out_byte,
	output logic         has_byte,
	output logic         segment_end,
	output logic         packet_done,
	output logic [1:0]   packet_class,
	output logic [15:0]  written_count
);

	logic [HDR_IDX_W-1:0]  step_q;
	logic                  out_valid_q;
	logic [7:0]            byte_q;
	logic                  has_q;
	logic                  seg_q;
	logic                  done_q;
	logic [1:0]            cls_q;
	logic [15:0]           count_q;

	logic                  adv;
	logic [HDR_IDX_W-1:0]  total;
	logic [HDR_IDX_W-1:0]  hi;
	logic                  final_step;
	logic [7:0]            r_byte;
	logic                  r_has;
	logic                  r_seg;
	logic                  r_done;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !empty && final_step;

	// Result for the current step of the head command
	always_comb begin
		total = HDR_IDX_W'(head.newline) + head.nbytes;
		hi = step_q - HDR_IDX_W'(head.newline);
		final_step = 1'b1;
		r_byte = head.data;
		r_has = head.has;
		r_seg = head.seg;
		r_done = head.done;
		if (head.kind == CMD_FLUSH) begin
			if (total == '0) begin
				// ClientHello that ends with nothing sent
				r_byte = 8'd0;
				r_has = 1'b0;
				r_seg = 1'b0;
			end else begin
				final_step = (step_q == total - 1'b1);
				r_has = 1'b1;
				r_done = head.done && final_step;
				if (head.newline && (step_q == '0)) begin
					r_byte = NEWLINE_BYTE;
					r_seg = 1'b1;
				end else begin
					r_byte = (32'(hi) < HEADER_BYTES) ? head.hdr[hi] : 8'd0;
					r_seg = head.seg_each || r_done;
				end
			end
		end
	end

	// Step counter and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= !empty;
			if (!empty) begin
				step_q <= final_step ? '0 : step_q + 1'b1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv && !empty) begin
			byte_q <= r_has ? r_byte : 8'd0;
			has_q <= r_has;
			seg_q <= r_seg;
			done_q <= r_done;
			cls_q <= head.cls;
			count_q <= r_done ? head.count : 16'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = byte_q;
	assign has_byte      = has_q;
	assign segment_end   = seg_q;
	assign packet_done   = done_q;
	assign packet_class  = cls_q;
	assign written_count = count_q;

endmodule

### design/tls_hello_http_segmenter.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    in_byte, last_byte
// result    out        out_valid / out_stall  out_byte, has_byte, segment_end,
//                                             packet_done, packet_class, written_count
// config    in         cfg_valid / cfg_ready  cfg_data (fragment_limit)
//
// The front takes one byte per cycle while in_stall is low; the first header bytes of a buffer give no result.
// Classification queues a flush that the back emits at one result per cycle unless out_stall holds it, up to 12.
// A two-entry command queue between them sets in_stall; it is high while the queue is full.
// out_stall holds the output register; the back advances only when it is free.
// Reset clears all control state and sets fragment_limit to 40; cfg_ready is always high.

module tls_hello_http_segmenter
	import thhs_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic [7:0]   in_byte,
	input  logic         last_byte,
	output logic         out_valid,
	input  logic         out_stall,
	output logic [7:0]   out_byte,
	output logic         has_byte,
	output logic         segment_end,
	output logic         packet_done,
	output logic [1:0]   packet_class,
	output logic [15:0]  written_count,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);

	logic [7:0]  fragment_limit_q;
	logic        accept;
	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	entry_t      q_in;
	entry_t      q_head;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_full;
	assign accept    = in_valid && !q_full;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fragment_limit_q <= 8'd40;
		end else if (cfg_valid && cfg_ready) begin
			fragment_limit_q <= cfg_data;
		end
	end

	thhs_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.in_byte        (in_byte),
		.last_byte      (last_byte),
		.fragment_limit (fragment_limit_q),
		.push           (q_push),
		.push_entry     (q_in)
	);

	thhs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.full       (q_full),
		.empty      (q_empty),
		.head       (q_head)
	);

	thhs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.empty         (q_empty),
		.head          (q_head),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.segment_end   (segment_end),
		.packet_done   (packet_done),
		.packet_class  (packet_class),
		.written_count (written_count)
	);

`ifndef SYNTHESIS
	// Count is only reported on the final result of a buffer
	a_count_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !packet_done) |-> (written_count == 16'd0))
		else $error("written_count nonzero without packet_done");

	// A result without a byte only closes a buffer
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (packet_done && !segment_end && out_byte == 8'd0))
		else $error("byteless result that is not a bare completion");

	// ClientHello bytes always go out one per segment
	a_tls_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && has_byte && packet_class == CLS_TLS) |-> segment_end)
		else $error("ClientHello byte not closed as its own segment");

	// Queue never written while full
	a_queue_push: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_push)
		else $error("command pushed into a full queue");
`endif

endmodule

### sim/tls_hello_http_segmenter_tb.sv
`timescale 1ns / 1ps

module tls_hello_http_segmenter_tb
	import thhs_pkg::*;
();

	localparam int COUNT_BITS = 16;
	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
	// Cycles without any transaction before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// Settle time after the last expected result (command queue plus output register)
	localparam int DRAIN_CYCLES = 20;
	localparam int REPORT_MAX = 40;

	// Record layer and handshake header values
	localparam logic [7:0] TLS_HANDSHAKE    = 8'd22;
	localparam logic [7:0] TLS_CLIENT_HELLO = 8'd1;
	localparam logic [7:0] TLS_MAJOR        = 8'd3;
	localparam logic [7:0] TLS_MINOR_MAX    = 8'd3;

	typedef struct packed {
		logic [7:0]  data;
		logic        has;
		logic        seg;
		logic        done;
		cls_t        cls;
		logic [15:0] count;
	} seg_result_t;

	// Segmentation predictor and ordered store of pending segment results
	class segment_scoreboard;
		string       methods [7];
		logic [7:0]  hdr [HEADER_BYTES];
		int unsigned byte_cnt;
		cls_t        cls;
		bit          classified;
		logic [7:0]  limit;
		logic [7:0]  held_limit;
		seg_result_t due [$];
		int          errors;
		int          reports;

		function new();
			methods = '{"GET ", "HEAD ", "POST ", "PUT ", "DELETE ", "CONNECT ", "OPTIONS "};
			limit = 8'd40;
			held_limit = 8'd0;
			errors = 0;
			reports = 0;
			end_buffer();
		endfunction

		function void end_buffer();
			byte_cnt = 0;
			cls = CLS_OTHER;
			classified = 1'b0;
		endfunction

		function void emit(logic [7:0] b, bit has, bit seg);
			seg_result_t r;
			r.data = has ? b : 8'd0;
			r.has = has;
			r.seg = seg;
			r.done = 1'b0;
			r.cls = cls;
			r.count = 16'd0;
			due.push_back(r);
		endfunction

		// Final result of the buffer carries done and the written count
		function void close_buffer(int unsigned written);
			seg_result_t r;
			r = due.pop_back();
			r.done = 1'b1;
			r.count = (written > 16'hFFFF) ? 16'hFFFF : written[15:0];
			due.push_back(r);
		endfunction

		function cls_t classify(int unsigned len);
			int  m;
			int  i;
			bit  match;
			if (len >= HEADER_BYTES && hdr[0] == TLS_HANDSHAKE && hdr[5] == TLS_CLIENT_HELLO &&
					hdr[1] == TLS_MAJOR && hdr[2] <= TLS_MINOR_MAX &&
					hdr[9] == TLS_MAJOR && hdr[10] <= TLS_MINOR_MAX)
				return CLS_TLS;
			for (m = 0; m < 7; m++) begin
				match = (len >= methods[m].len());
				for (i = 0; match && i < methods[m].len(); i++)
					if (hdr[i] != methods[m][i])
						match = 1'b0;
				if (match)
					return CLS_HTTP;
			end
			return CLS_OTHER;
		endfunction

		// Work out the results caused by one accepted byte
		function void note_byte(logic [7:0] b, bit last);
			int unsigned idx;
			int unsigned len;
			int unsigned k;
			int unsigned i;
			idx = byte_cnt;
			if (byte_cnt < COUNT_MAX)
				byte_cnt++;
			if (!classified) begin
				if (idx < HEADER_BYTES)
					hdr[idx] = b;
				if (byte_cnt < HEADER_BYTES && !last)
					return;
				len = byte_cnt;
				classified = 1'b1;
				held_limit = limit;
				cls = classify(len);
				if (cls == CLS_TLS) begin
					k = (len < held_limit) ? len : held_limit;
					for (i = 0; i < k; i++)
						emit(hdr[i], 1'b1, 1'b1);
					if (last) begin
						if (k == 0)
							emit(8'd0, 1'b0, 1'b0);
						close_buffer(k);
					end
				end else begin
					if (cls == CLS_HTTP)
						emit(NEWLINE_BYTE, 1'b1, 1'b1);
					for (i = 0; i < len; i++)
						emit(hdr[i], 1'b1, last && (i + 1 == len));
					if (last)
						close_buffer(byte_cnt);
				end
			end else if (cls == CLS_TLS) begin
				// bytes past the latched limit are dropped
				k = 0;
				if (idx < held_limit) begin
					emit(b, 1'b1, 1'b1);
					k = 1;
				end
				if (last) begin
					if (k == 0)
						emit(8'd0, 1'b0, 1'b0);
					close_buffer((byte_cnt < held_limit) ? byte_cnt : held_limit);
				end
			end else begin
				emit(b, 1'b1, last);
				if (last)
					close_buffer(byte_cnt);
			end
			if (last)
				end_buffer();
		endfunction

		function void report(string field, int unsigned e, int unsigned a);
			errors++;
			if (reports < REPORT_MAX)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
			reports++;
		endfunction

		function void check_result(seg_result_t got);
			seg_result_t exp_r;
			if (due.size() == 0) begin
				errors++;
				if (reports < REPORT_MAX)
					$display("%0t: unexpected result, expected none, actual out_byte %0d done %0d",
						$time, got.data, got.done);
				reports++;
				return;
			end
			exp_r = due.pop_front();
			if (got.data !== exp_r.data)
				report("out_byte", exp_r.data, got.data);
			if (got.has !== exp_r.has)
				report("has_byte", exp_r.has, got.has);
			if (got.seg !== exp_r.seg)
				report("segment_end", exp_r.seg, got.seg);
			if (got.done !== exp_r.done)
				report("packet_done", exp_r.done, got.done);
			if (got.cls !== exp_r.cls)
				report("packet_class", exp_r.cls, got.cls);
			if (got.count !== exp_r.count)
				report("written_count", exp_r.count, got.count);
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        has_byte;
	logic        segment_end;
	logic        packet_done;
	logic [1:0]  packet_class;
	logic [15:0] written_count;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;

	int in_idle_pct = 0;
	int out_idle_pct = 0;
	logic [7:0] frame [$];
	segment_scoreboard sb = new();

	tls_hello_http_segmenter #(
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.has_byte(has_byte),
		.segment_end(segment_end),
		.packet_done(packet_done),
		.packet_class(packet_class),
		.written_count(written_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result monitor and random receiver stall
	always @(posedge clk) begin : result_monitor
		seg_result_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.data = out_byte;
			got.has = has_byte;
			got.seg = segment_end;
			got.done = packet_done;
			got.cls = cls_t'(packet_class);
			got.count = written_count;
			sb.check_result(got);
		end
		out_stall <= ($urandom_range(0, 99) < out_idle_pct);
	end

	// Hang detection: any transaction restarts the count
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// ClientHello header with valid versions, then payload bytes
	function automatic void add_hello(int extra);
		frame.push_back(TLS_HANDSHAKE);
		frame.push_back(TLS_MAJOR);
		frame.push_back(8'($urandom_range(0, TLS_MINOR_MAX)));
		repeat (2) frame.push_back(rand_byte());
		frame.push_back(TLS_CLIENT_HELLO);
		repeat (3) frame.push_back(rand_byte());
		frame.push_back(TLS_MAJOR);
		frame.push_back(8'($urandom_range(0, TLS_MINOR_MAX)));
		repeat (extra) frame.push_back(rand_byte());
	endfunction

	function automatic void add_request(int m, int extra);
		int i;
		for (i = 0; i < sb.methods[m].len(); i++)
			frame.push_back(sb.methods[m][i]);
		repeat (extra) frame.push_back(8'($urandom_range(32, 126)));
	endfunction

	// Send the frame, last mark on its final byte; valid drops for random idle gaps between items
	task automatic send_frame();
		int i;
		bit last;
		for (i = 0; i < frame.size(); i++) begin
			last = (i == frame.size() - 1);
			if ($urandom_range(0, 99) < in_idle_pct) begin
				in_valid <= 1'b0;
				do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
			end
			in_valid <= 1'b1;
			in_byte <= frame[i];
			last_byte <= last;
			do @(posedge clk); while (in_stall);
			sb.note_byte(frame[i], last);
		end
		frame.delete();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.limit = value;
	endtask

	// Mostly well-formed hellos and requests, some corrupted, truncated or noise
	task automatic random_frames(int items);
		int sent;
		int pick;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				add_hello(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
			end else if (pick <= 6) begin
				add_request($urandom_range(0, 6), $urandom_range(0, 14));
			end else if (pick == 7) begin
				add_hello($urandom_range(0, 6));
				case ($urandom_range(0, 5))
					0: frame[0] ^= 8'($urandom_range(1, 255));
					1: frame[1] ^= 8'($urandom_range(1, 255));
					2: frame[2] ^= 8'($urandom_range(1, 255));
					3: frame[5] ^= 8'($urandom_range(1, 255));
					4: frame[9] ^= 8'($urandom_range(1, 255));
					default: frame[10] ^= 8'($urandom_range(1, 255));
				endcase
			end else if (pick == 8) begin
				add_request($urandom_range(0, 6), 0);
				repeat ($urandom_range(1, frame.size() - 1)) void'(frame.pop_back());
			end else begin
				repeat ($urandom_range(1, 12)) frame.push_back(rand_byte());
			end
			sent += frame.size();
			send_frame();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		in_idle_pct = 36;
		out_idle_pct = 82;

		// Short request ending inside the header, single-byte buffer, reset limit
		add_request(0, 0);
		send_frame();
		frame.push_back(8'hFF);
		send_frame();

		// Final hello byte past a limit of one
		wait_idle();
		write_limit(8'd1);
		add_hello(1);
		send_frame();

		// Zero limit: hello sends nothing
		wait_idle();
		write_limit(8'd0);
		add_hello(0);
		send_frame();

		wait_idle();
		write_limit(8'd255);
		random_frames(20);

		wait_idle();
		in_idle_pct = 82;
		out_idle_pct = 36;
		write_limit(8'($urandom_range(2, 12)));
		random_frames(20);

		wait_idle();
		in_idle_pct = 0;
		out_idle_pct = 0;
		write_limit(8'($urandom_range(13, 254)));
		random_frames(20);

		wait_idle();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
